FILE: hdl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Request kinds and result status codes of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

	typedef enum logic [1:0] {
		KIND_CREATE  = 2'd0,
		KIND_DESTROY = 2'd1,
		KIND_CHECK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_FULL    = 2'd2
	} status_t;

endpackage

FILE: hdl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out (index, generation) handles for a fixed pool of slots, with a
// LIFO free stack; checks and destroys handles.
// ----------------------------------------------------------------------------
// channel  dir  handshake          tuser  tdata
// s_*      in   s_tvalid/s_tready  kind   handle_index, generation, failed
// m_*      out  m_tvalid/m_tready  -      out_index, out_generation,
//                                         handle_valid, status
//
// One request per cycle sustained while results are taken; a result is presented
// from the result register once its request leaves stage 1 (RAM read and stage 1
// on the accepting edge, result register on the edge that commits stage 1).
// Slot table and free stack are block RAMs read ahead of use; writes from
// stage 1 are forwarded to the next read. Reset clears counters and flags, not
// the RAMs: the used-slot count gates every table read, so no clearing pass is needed.
// A stalled result holds stage 1; stage 1 takes a new request as it drains.
// ----------------------------------------------------------------------------
module generational_handle_allocator
	import gha_pkg::*;
#(
	parameter int SLOTS = 1024,
	parameter int GEN_BITS = 16,
	localparam int IDX_W = $clog2(SLOTS),
	localparam int CNT_W = $clog2(SLOTS + 1),
	localparam int IN_W = IDX_W + GEN_BITS + 1,
	localparam int IN_TW = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W = IDX_W + GEN_BITS + 3,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// handle_index, handle_generation, handle_failed, zero pad
	input  logic [IN_TW-1:0]  s_tdata,
	// kind
	input  logic [1:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// out_index, out_generation, handle_valid, status, zero pad
	output logic [OUT_TW-1:0] m_tdata
);

	typedef struct packed {
		logic                live;
		logic [GEN_BITS-1:0] gen;
	} entry_t;

	typedef struct packed {
		logic [GEN_BITS-1:0] gen;
		logic [IDX_W-1:0]    idx;
	} free_t;

	// stage 1
	logic                valid_s1;
	logic [1:0]          kind_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [GEN_BITS-1:0] gen_s1;
	logic                failed_s1;

	// result register
	logic                res_valid_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [GEN_BITS-1:0] res_gen_q;
	logic                res_ok_q;
	status_t             res_status_q;

	logic [CNT_W-1:0] used_slots_q, used_slots_n;
	logic [CNT_W-1:0] free_count_q, free_count_n;

	logic accept, commit;

	logic [IDX_W-1:0] tbl_raddr, tbl_waddr;
	entry_t           tbl_rdata, tbl_wdata, tbl_byp_data_q, tbl_entry;
	logic             tbl_we, tbl_byp_q;

	logic [IDX_W-1:0] stk_raddr, stk_waddr;
	free_t            stk_rdata, stk_wdata, stk_byp_data_q, stk_top;
	logic             stk_we, stk_byp_q;

	logic [CNT_W-1:0] fc_eff, fc_dec;
	logic             handle_ok;

	logic [IDX_W-1:0]    r_idx;
	logic [GEN_BITS-1:0] r_gen;
	logic                r_ok;
	status_t             r_status;

	assign commit   = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || commit;
	assign accept   = s_tvalid && s_tready;

	assign tbl_entry = tbl_byp_q ? tbl_byp_data_q : tbl_rdata;
	assign stk_top   = stk_byp_q ? stk_byp_data_q : stk_rdata;

	assign handle_ok = (CNT_W'(idx_s1) < used_slots_q) && tbl_entry.live
		&& (tbl_entry.gen == gen_s1) && !failed_s1;

	always_comb begin
		free_count_n = free_count_q;
		used_slots_n = used_slots_q;
		tbl_we       = 1'b0;
		tbl_waddr    = idx_s1;
		tbl_wdata    = '0;
		stk_we       = 1'b0;
		stk_waddr    = free_count_q[IDX_W-1:0];
		stk_wdata    = '0;
		r_idx        = '0;
		r_gen        = '0;
		r_ok         = 1'b0;
		r_status     = STATUS_OK;
		case (kind_s1)
			KIND_CREATE: begin
				if (free_count_q != '0) begin
					free_count_n = free_count_q - CNT_W'(1);
					tbl_we       = commit;
					tbl_waddr    = stk_top.idx;
					tbl_wdata    = '{live: 1'b1, gen: stk_top.gen};
					r_idx        = stk_top.idx;
					r_gen        = stk_top.gen;
				end else if (used_slots_q != CNT_W'(SLOTS)) begin
					used_slots_n = used_slots_q + CNT_W'(1);
					tbl_we       = commit;
					tbl_waddr    = used_slots_q[IDX_W-1:0];
					tbl_wdata    = '{live: 1'b1, gen: '0};
					r_idx        = used_slots_q[IDX_W-1:0];
				end else begin
					r_status = STATUS_FULL;
				end
			end
			KIND_DESTROY: begin
				if (handle_ok) begin
					r_ok         = 1'b1;
					free_count_n = free_count_q + CNT_W'(1);
					tbl_we       = commit;
					tbl_wdata    = '{live: 1'b0, gen: tbl_entry.gen + GEN_BITS'(1)};
					stk_we       = commit;
					stk_wdata    = '{gen: tbl_entry.gen + GEN_BITS'(1), idx: idx_s1};
				end else begin
					r_status = STATUS_INVALID;
				end
			end
			KIND_CHECK: begin
				r_ok = handle_ok;
			end
			default: begin
			end
		endcase
	end

	// read ahead, against the state left after this cycle's commit
	assign tbl_raddr = accept ? s_tdata[IDX_W-1:0] : idx_s1;
	assign fc_eff    = commit ? free_count_n : free_count_q;
	assign fc_dec    = fc_eff - CNT_W'(1);
	assign stk_raddr = fc_dec[IDX_W-1:0];

	gha_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	gha_ram #(
		.WIDTH ($bits(free_t)),
		.DEPTH (SLOTS)
	) u_free_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			res_valid_q  <= 1'b0;
			used_slots_q <= '0;
			free_count_q <= '0;
			tbl_byp_q    <= 1'b0;
			stk_byp_q    <= 1'b0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !commit);
			res_valid_q <= commit || (res_valid_q && !m_tready);
			if (commit) begin
				used_slots_q <= used_slots_n;
				free_count_q <= free_count_n;
			end
			tbl_byp_q <= tbl_we && (tbl_waddr == tbl_raddr);
			stk_byp_q <= stk_we && (stk_waddr == stk_raddr);
		end
	end

	always_ff @(posedge clk) begin
		tbl_byp_data_q <= tbl_wdata;
		stk_byp_data_q <= stk_wdata;
		if (accept) begin
			kind_s1   <= s_tuser;
			idx_s1    <= s_tdata[IDX_W-1:0];
			gen_s1    <= s_tdata[IDX_W +: GEN_BITS];
			failed_s1 <= s_tdata[IDX_W + GEN_BITS];
		end
		if (commit) begin
			res_idx_q    <= r_idx;
			res_gen_q    <= r_gen;
			res_ok_q     <= r_ok;
			res_status_q <= r_status;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = OUT_TW'({res_status_q, res_ok_q, res_gen_q, res_idx_q});

	a_free_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= used_slots_q)
		else $error("free count exceeds used slots");

	a_used_le_slots: assert property (@(posedge clk) disable iff (!arst_n)
		used_slots_q <= CNT_W'(SLOTS))
		else $error("used slot count beyond pool size");

	a_destroy_push: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (kind_s1 == KIND_DESTROY) && handle_ok
		|=> free_count_q == $past(free_count_q) + CNT_W'(1))
		else $error("valid destroy did not push the free stack");

	a_commit_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid)
		else $error("committed request produced no result");

endmodule

FILE: verif/tb_generational_handle_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator
// Streams create, destroy and check requests into the allocator and compares
// every result against an in-order shadow of the slot pool (live flags,
// generations, LIFO free stack, high-water mark). Covers handle validity
// rules, slot reuse, pool exhaustion, output backpressure and random gaps.
// ----------------------------------------------------------------------------
module tb_generational_handle_allocator;
	import gha_pkg::*;

	localparam int NSLOT = 1024;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  idx;
		logic [15:0] gen;
		logic        failed;
	} alloc_req_t;

	typedef struct packed {
		logic [9:0]  idx;
		logic [15:0] gen;
		logic        valid;
		status_t     status;
	} alloc_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	generational_handle_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	// shadow of the slot pool
	logic        slot_alive [NSLOT];
	logic [15:0] slot_gen [NSLOT];
	logic [9:0]  free_lifo [NSLOT];
	int          free_depth = 0;
	int          high_water = 0;

	alloc_req_t  req_q[$];
	alloc_res_t  result_q[$];
	alloc_req_t  cur_req;

	logic steady = 1'b0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   cycle_cnt = 0;
	int   fail_cnt = 0;
	int   n_req = 0, n_created = 0, n_full = 0, n_destroyed = 0;
	int   n_rejected = 0, n_check_ok = 0, n_results = 0;

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			slot_alive[i] = 1'b0;
			slot_gen[i] = '0;
			free_lifo[i] = '0;
		end
	end

	function automatic logic handle_live(alloc_req_t r);
		return (int'(r.idx) < high_water) && slot_alive[r.idx] &&
			(r.gen == slot_gen[r.idx]) && !r.failed;
	endfunction

	// advance the shadow pool by one accepted request
	function automatic alloc_res_t apply_request(alloc_req_t r);
		alloc_res_t res;
		logic [9:0] slot;
		res = '{idx: '0, gen: '0, valid: 1'b0, status: STATUS_OK};
		n_req++;
		case (r.kind)
			KIND_CREATE: begin
				if (free_depth > 0) begin
					free_depth--;
					slot = free_lifo[free_depth];
				end else if (high_water < NSLOT) begin
					slot = high_water[9:0];
					high_water++;
					slot_gen[slot] = '0;
				end else begin
					res.status = STATUS_FULL;
					n_full++;
					return res;
				end
				slot_alive[slot] = 1'b1;
				res.idx = slot;
				res.gen = slot_gen[slot];
				n_created++;
			end
			KIND_DESTROY: begin
				if (handle_live(r)) begin
					res.valid = 1'b1;
					slot_alive[r.idx] = 1'b0;
					if (free_depth < NSLOT) begin
						free_lifo[free_depth] = r.idx;
						free_depth++;
					end
					slot_gen[r.idx] = slot_gen[r.idx] + 16'd1;
					n_destroyed++;
				end else begin
					res.status = STATUS_INVALID;
					n_rejected++;
				end
			end
			KIND_CHECK: begin
				res.valid = handle_live(r);
				if (res.valid)
					n_check_ok++;
			end
			default: ;
		endcase
		return res;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				result_q.push_back(apply_request(cur_req));
			if (!s_tvalid || s_tready) begin
				if (req_q.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
					cur_req = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_req.kind;
					s_tdata <= {5'd0, cur_req.failed, cur_req.gen, cur_req.idx};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		alloc_res_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.idx = m_tdata[9:0];
				got.gen = m_tdata[25:10];
				got.valid = m_tdata[26];
				got.status = status_t'(m_tdata[28:27]);
				n_results++;
				if (result_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("ERROR: unexpected result idx=%0d gen=%0d valid=%0b status=%0d",
							got.idx, got.gen, got.valid, got.status);
				end else begin
					want = result_q.pop_front();
					if (got.idx !== want.idx || got.gen !== want.gen ||
						got.valid !== want.valid || got.status !== want.status) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display({"ERROR: result %0d exp idx=%0d gen=%0d valid=%0b ",
								"status=%0d, got idx=%0d gen=%0d valid=%0b status=%0d"},
								n_results, want.idx, want.gen, want.valid, want.status,
								got.idx, got.gen, got.valid, got.status);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 36);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_cnt, result_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_req(alloc_req_t r);
		while (req_q.size() >= 2)
			@(negedge clk);
		req_q.push_back(r);
	endtask

	task automatic send(logic [1:0] kind, int idx, int gen, logic failed);
		alloc_req_t r;
		r.kind = kind;
		r.idx = idx[9:0];
		r.gen = gen[15:0];
		r.failed = failed;
		push_req(r);
	endtask

	task automatic drain();
		while (req_q.size() > 0 || s_tvalid || result_q.size() > 0)
			@(negedge clk);
	endtask

	// mostly handles that are live right now, some stale, failed or random
	function automatic alloc_req_t pick_handle(logic [1:0] kind);
		alloc_req_t r;
		int mode;
		r.kind = kind;
		r.idx = 10'($urandom_range(NSLOT - 1));
		r.gen = 16'($urandom);
		r.failed = 1'($urandom_range(1));
		mode = $urandom_range(99);
		if (high_water > 0 && mode < 85) begin
			r.idx = 10'($urandom_range(high_water - 1));
			for (int i = 0; i < 8 && !slot_alive[r.idx]; i++)
				r.idx = 10'($urandom_range(high_water - 1));
			r.gen = slot_gen[r.idx];
			r.failed = 1'b0;
			if (mode >= 78)
				r.gen = r.gen - 16'd1;
			else if (mode >= 72)
				r.failed = 1'b1;
		end else if (mode >= 95) begin
			r.idx = '1;
			r.gen = '1;
		end
		return r;
	endfunction

	task automatic issue_mix(int n, int create_pct);
		alloc_req_t r;
		int roll;
		for (int k = 0; k < n; k++) begin
			while (req_q.size() >= 2)
				@(negedge clk);
			roll = $urandom_range(99);
			if (roll < create_pct)
				r = pick_handle(KIND_CREATE);
			else if (roll < create_pct + (100 - create_pct) / 2)
				r = pick_handle(KIND_DESTROY);
			else begin
				r = pick_handle(KIND_CHECK);
				if (roll >= 97)
					r.kind = 2'd3;
			end
			push_req(r);
		end
	endtask

	initial begin
		int fill_n;
		int extra;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed
		send(KIND_CHECK, 0, 0, 1'b0);        // empty pool, index out of range
		send(KIND_DESTROY, 0, 0, 1'b0);      // rejected
		send(KIND_CREATE, 0, 0, 1'b0);
		send(KIND_CREATE, 1023, 65535, 1'b1);
		send(KIND_CHECK, 0, 0, 1'b0);
		send(KIND_CHECK, 0, 0, 1'b1);        // failed flag
		send(KIND_CHECK, 0, 1, 1'b0);        // wrong generation
		send(KIND_CHECK, 2, 0, 1'b0);        // beyond high water
		send(KIND_CHECK, 1023, 65535, 1'b1);
		send(2'd3, 1023, 65535, 1'b1);       // unknown kind
		send(KIND_DESTROY, 0, 0, 1'b0);
		send(KIND_CHECK, 0, 0, 1'b0);        // dead slot
		send(KIND_DESTROY, 0, 0, 1'b0);      // double destroy
		send(KIND_CREATE, 0, 0, 1'b0);       // reuse, generation 1
		send(KIND_DESTROY, 1, 0, 1'b0);
		send(KIND_DESTROY, 0, 1, 1'b0);
		send(KIND_CREATE, 0, 0, 1'b0);       // LIFO top
		send(KIND_CREATE, 0, 0, 1'b0);
		send(KIND_CREATE, 0, 0, 1'b0);       // fresh slot
		send(KIND_DESTROY, 2, 65535, 1'b0);
		send(KIND_CHECK, 1, 1, 1'b0);

		issue_mix(350, 45);
		drain();

		// exhaust the pool, then push past it; each interleaved mix may free
		// one slot, so it adds one more create
		fill_n = free_depth + (NSLOT - high_water);
		extra = 0;
		steady = 1'b1;
		for (int k = 0; k < fill_n + 6 + extra; k++) begin
			if (k == fill_n / 2)
				steady = 1'b0;
			send(KIND_CREATE, $urandom_range(NSLOT - 1), $urandom_range(65535),
				1'($urandom_range(1)));
			if ($urandom_range(7) == 0) begin
				issue_mix(1, 0);
				extra++;
			end
		end
		send(KIND_CHECK, 1023, 0, 1'b0);

		// long output stall while requests keep coming
		hold_req = 1'b1;
		issue_mix(300, 30);

		drain();
		repeat (20) @(negedge clk);
		$display("run: %0d requests, %0d creates, %0d pool-full, %0d destroys, %0d rejected",
			n_req, n_created, n_full, n_destroyed, n_rejected);
		$display("run: %0d valid checks, %0d mismatches", n_check_ok, fail_cnt);
		if (fail_cnt == 0 && result_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/gha_pkg.sv
hdl/gha_ram.sv
hdl/generational_handle_allocator.sv
verif/tb_generational_handle_allocator.sv
